/* src/url_percent_decoder_macros.svh */
//------------------------------------------------------------------------------
// URL percent decoder assertion macros
// Shared wrappers for clocked implication checks under async reset.
//------------------------------------------------------------------------------
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

// same-cycle implication
`define URLDEC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("urldec check failed");

// next-cycle implication
`define URLDEC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("urldec check failed");

`endif

/* src/urldec_pkg.sv */
//------------------------------------------------------------------------------
// URL percent decoder package
// Beat types, character codes, escape phase encoding and helper functions.
//------------------------------------------------------------------------------
package urldec_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} result_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'b001,
		PH_FIRST  = 3'b010,
		PH_SECOND = 3'b100
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} hex_t;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOW_A   = 8'h61;
	localparam logic [7:0] CH_LOW_F   = 8'h66;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_F    = 8'h46;
	localparam logic [3:0] ALPHA_ADJ  = 4'd9;

	function automatic hex_t hex_digit(input logic [7:0] b);
		hex_t h;
		h.valid = 1'b0;
		h.value = 4'd0;
		if (b inside {[CH_ZERO:CH_NINE]}) begin
			h.valid = 1'b1;
			h.value = b[3:0];
		end else if ((b inside {[CH_LOW_A:CH_LOW_F]}) || (b inside {[CH_UP_A:CH_UP_F]})) begin
			h.valid = 1'b1;
			h.value = b[3:0] + ALPHA_ADJ;
		end
		return h;
	endfunction

	function automatic logic [7:0] blank_controls(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		if (v inside {CH_NUL, CH_TAB, CH_NL, CH_CR})
			r = CH_SPACE;
		return r;
	endfunction

endpackage

/* src/urldec_core.sv */
//------------------------------------------------------------------------------
// URL percent decoder core
// Escape state registers and single-pass decode of the staged input beat.
//------------------------------------------------------------------------------
module urldec_core import urldec_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    fire,
	output logic    emit,
	output result_t result
);

	phase_t     phase_q, phase_d;
	logic [3:0] held_nibble_q, held_nibble_d;
	logic       first_valid_q, first_valid_d;
	hex_t       hex;
	logic [7:0] value;

	always_comb begin
		hex             = hex_digit(item.in_byte);
		phase_d         = PH_IDLE;
		held_nibble_d   = 4'd0;
		first_valid_d   = 1'b0;
		emit            = 1'b1;
		value           = 8'd0;
		result.out_last = item.in_last;
		result.out_byte = 8'd0;
		case (phase_q)
			PH_FIRST: begin
				if (!item.in_last) begin
					phase_d       = PH_SECOND;
					held_nibble_d = hex.valid ? hex.value : 4'd0;
					first_valid_d = hex.valid;
					emit          = 1'b0;
				end
				value           = hex.valid ? {4'd0, hex.value} : 8'd0;
				result.out_byte = blank_controls(value);
			end
			PH_SECOND: begin
				if (!first_valid_q)
					value = 8'd0;
				else if (hex.valid)
					value = {held_nibble_q, hex.value};
				else
					value = {4'd0, held_nibble_q};
				result.out_byte = blank_controls(value);
			end
			default: begin
				if (item.in_byte == CH_PERCENT) begin
					result.out_byte = CH_SPACE;
					if (!item.in_last) begin
						phase_d = PH_FIRST;
						emit    = 1'b0;
					end
				end else if (item.in_byte == CH_PLUS) begin
					result.out_byte = CH_SPACE;
				end else begin
					result.out_byte = item.in_byte;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			held_nibble_q <= 4'd0;
			first_valid_q <= 1'b0;
		end else if (fire) begin
			phase_q       <= phase_d;
			held_nibble_q <= held_nibble_d;
			first_valid_q <= first_valid_d;
		end
	end

endmodule

/* src/urldec_out_reg.sv */
//------------------------------------------------------------------------------
// URL percent decoder output register
// Holds one decoded beat until the downstream side takes it.
//------------------------------------------------------------------------------
module urldec_out_reg import urldec_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    full,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic    valid_q;
	result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end

	assign full         = valid_q && !result_ready;
	assign result_valid = valid_q;
	assign result       = data_q;

endmodule

/* src/url_percent_decoder.sv */
// An accepted beat passes the input register and the decode core; its result beat
// waits in the output register. One input beat per cycle while the output is taken;
// a '%' and its first data byte give no result. The input and output registers each
// hold one beat, so stalls cost no bubbles once the output is taken again.
// Reset (arst_n low, asynchronous) empties both registers and clears the escape state.
//------------------------------------------------------------------------------
// URL percent decoder top level
// Input stage register, decode core and output register.
//------------------------------------------------------------------------------
`include "url_percent_decoder_macros.svh"

module url_percent_decoder import urldec_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic    valid_s1;
	item_t   item_s1;
	logic    emit;
	logic    advance;
	logic    out_full;
	result_t decoded;

	assign advance    = valid_s1 && (!emit || !out_full);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	urldec_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (advance),
		.emit   (emit),
		.result (decoded)
	);

	urldec_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (advance && emit),
		.push_data    (decoded),
		.full         (out_full),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	`URLDEC_ASSERT_NEXT(a_accept_fills_s1, item_valid && item_ready, valid_s1)
	`URLDEC_ASSERT_NOW(a_stall_cause, !item_ready, valid_s1 && emit && result_valid && !result_ready)
	`URLDEC_ASSERT_NEXT(a_emit_loads_out, advance && emit, result_valid)
	`URLDEC_ASSERT_NEXT(a_blocked_holds, valid_s1 && !advance, valid_s1 && $stable(item_s1))

endmodule

/* tb/sv/url_percent_decoder_tb.sv */
//------------------------------------------------------------------------------
// URL percent decoder testbench
// Drives escaped byte strings through the decoder with random idle cycles on
// both sides. A short directed table covers the edge cases, then random
// strings follow, mostly well-formed escapes. Each result beat is compared
// with a behavioral decoder that runs alongside the block, or with a pinned row's own result.
//------------------------------------------------------------------------------
module url_percent_decoder_tb;
	import urldec_pkg::*;

	localparam int N_RANDOM    = 1950;
	localparam int PAUSE_AT    = 1000;
	localparam int HOLD_AT     = 400;
	localparam int HOLD_CYCLES = 120;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		item_t   beat;
		logic    pinned;
		result_t want;
	} plan_row_t;

	// pinned rows carry their own expected result
	localparam int N_PLAN = 28;
	plan_row_t plan [N_PLAN] = '{
		{8'h41, 1'b0, 1'b1, 8'h41, 1'b0},
		{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0},
		{8'h01, 1'b0, 1'b1, 8'h01, 1'b0},
		{CH_NUL, 1'b0, 1'b1, CH_NUL, 1'b0},
		{CH_PLUS, 1'b0, 1'b1, CH_SPACE, 1'b0},
		{CH_PERCENT, 1'b1, 1'b1, CH_SPACE, 1'b1},
		{CH_PERCENT, 1'b0, 1'b0, CH_NUL, 1'b0},
		{8'h30, 1'b0, 1'b0, CH_NUL, 1'b0},
		{8'h39, 1'b0, 1'b0, CH_NUL, 1'b0},
		{CH_PERCENT, 1'b0, 1'b0, CH_NUL, 1'b0},
		{8'h30, 1'b0, 1'b0, CH_NUL, 1'b0},
		{8'h61, 1'b0, 1'b0, CH_NUL, 1'b0},
		{CH_PERCENT, 1'b0, 1'b0, CH_NUL, 1'b0},
		{8'h30, 1'b0, 1'b0, CH_NUL, 1'b0},
		{8'h44, 1'b0, 1'b0, CH_NUL, 1'b0},
		{CH_PERCENT, 1'b0, 1'b0, CH_NUL, 1'b0},
		{CH_PERCENT, 1'b0, 1'b0, CH_NUL, 1'b0},
		{8'h41, 1'b0, 1'b0, CH_NUL, 1'b0},
		{CH_PERCENT, 1'b0, 1'b0, CH_NUL, 1'b0},
		{8'h37, 1'b0, 1'b0, CH_NUL, 1'b0},
		{8'h7A, 1'b0, 1'b0, CH_NUL, 1'b0},
		{CH_PERCENT, 1'b0, 1'b0, CH_NUL, 1'b0},
		{8'h63, 1'b1, 1'b0, CH_NUL, 1'b0},
		{CH_PERCENT, 1'b0, 1'b0, CH_NUL, 1'b0},
		{CH_NUL, 1'b1, 1'b1, CH_SPACE, 1'b1},
		{CH_PERCENT, 1'b0, 1'b0, CH_NUL, 1'b0},
		{8'h61, 1'b0, 1'b0, CH_NUL, 1'b0},
		{8'h44, 1'b1, 1'b0, CH_NUL, 1'b0}
	};

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	phase_t      esc_phase;
	logic [3:0]  esc_nibble;
	logic        esc_digit_ok;
	int          esc_left;
	result_t     pending_out [$];
	int          errors;
	int          results_seen;
	int unsigned cycle_count;

	url_percent_decoder uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial cycle_count = 0;
	always @(posedge clk) cycle_count <= cycle_count + 1;

	function automatic bit hex_value(input logic [7:0] b, output logic [3:0] v);
		logic [7:0] t;
		bit ok;
		t = 8'd0;
		ok = 1'b1;
		if (b >= CH_ZERO && b <= CH_NINE) t = b - CH_ZERO;
		else if (b >= CH_LOW_A && b <= CH_LOW_F) t = b - CH_LOW_A + 8'd10;
		else if (b >= CH_UP_A && b <= CH_UP_F) t = b - CH_UP_A + 8'd10;
		else ok = 1'b0;
		v = t[3:0];
		return ok;
	endfunction

	function automatic logic [7:0] mask_control(input logic [7:0] v);
		case (v)
			CH_NUL, CH_TAB, CH_NL, CH_CR: return CH_SPACE;
			default: return v;
		endcase
	endfunction

	function automatic void drop_escape();
		esc_phase = PH_IDLE;
		esc_nibble = 4'd0;
		esc_digit_ok = 1'b0;
	endfunction

	function automatic bit decode_beat(input item_t it, output result_t r);
		logic [3:0] d;
		logic [7:0] v;
		bit is_hex;
		r = '0;
		is_hex = hex_value(it.in_byte, d);
		case (esc_phase)
			PH_FIRST: begin
				esc_nibble = is_hex ? d : 4'd0;
				esc_digit_ok = is_hex;
				if (!it.in_last) begin
					esc_phase = PH_SECOND;
					return 1'b0;
				end
				r.out_byte = mask_control({4'd0, esc_nibble});
				r.out_last = 1'b1;
				drop_escape();
				return 1'b1;
			end
			PH_SECOND: begin
				if (!esc_digit_ok) v = CH_NUL;
				else if (is_hex) v = {esc_nibble, d};
				else v = {4'd0, esc_nibble};
				r.out_byte = mask_control(v);
				r.out_last = it.in_last;
				drop_escape();
				return 1'b1;
			end
			default: begin
				drop_escape();
				if (it.in_byte == CH_PERCENT) begin
					if (!it.in_last) begin
						esc_phase = PH_FIRST;
						return 1'b0;
					end
					r.out_byte = CH_SPACE;
					r.out_last = 1'b1;
					return 1'b1;
				end
				r.out_byte = (it.in_byte == CH_PLUS) ? CH_SPACE : it.in_byte;
				r.out_last = it.in_last;
				return 1'b1;
			end
		endcase
	endfunction

	// mostly well-formed escapes with random digits, some noise
	function automatic item_t draw_item();
		item_t it;
		logic [3:0] nib;
		int pick;
		it.in_last = ($urandom_range(0, 9) == 0);
		if (esc_left > 0) begin
			esc_left--;
			if ($urandom_range(0, 9) < 8) begin
				nib = 4'($urandom_range(0, 15));
				if (nib < 4'd10) it.in_byte = CH_ZERO + nib;
				else it.in_byte = ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + nib - 8'd10;
			end else begin
				it.in_byte = 8'($urandom_range(0, 255));
			end
		end else begin
			pick = int'($urandom_range(0, 99));
			if (pick < 35) begin
				it.in_byte = CH_PERCENT;
				esc_left = 2;
			end else if (pick < 42) it.in_byte = CH_PLUS;
			else if (pick < 47) it.in_byte = 8'($urandom_range(1, 15));
			else if (pick < 48) it.in_byte = CH_NUL;
			else it.in_byte = 8'($urandom_range(1, 255));
		end
		if (it.in_last) esc_left = 0;
		return it;
	endfunction

	// idle cycles before a beat, with stretches of back-to-back beats
	function automatic int pace(input int n);
		if ((n / 64) % 3 == 0) return 0;
		return int'($urandom_range(0, 10));
	endfunction

	task automatic push_item(input item_t it, input int gap, input logic pinned,
			input result_t want);
		result_t r;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(negedge clk); while (!item_ready);
		@(posedge clk);
		if (decode_beat(it, r)) pending_out.push_back(pinned ? want : r);
	endtask

	task automatic check_beat(input result_t got);
		result_t e;
		if (pending_out.size() == 0) begin
			$error("out_byte: expected none, actual %h (out_last %b)", got.out_byte,
				got.out_last);
			errors++;
			return;
		end
		e = pending_out.pop_front();
		if (got.out_byte !== e.out_byte) begin
			$error("out_byte: expected %h, actual %h", e.out_byte, got.out_byte);
			errors++;
		end
		if (got.out_last !== e.out_last) begin
			$error("out_last: expected %b, actual %b", e.out_last, got.out_last);
			errors++;
		end
	endtask

	initial begin
		int gap;
		result_ready = 1'b0;
		results_seen = 0;
		@(posedge arst_n);
		forever begin
			// hold off once long enough to back up the input
			gap = (results_seen == HOLD_AT) ? HOLD_CYCLES : pace(results_seen + 32);
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(negedge clk); while (!result_valid);
			check_beat(result);
			results_seen++;
			@(posedge clk);
		end
	end

	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("** url_percent_decoder: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		errors = 0;
		esc_left = 0;
		drop_escape();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_PLAN; i++)
			push_item(plan[i].beat, pace(i + 64), plan[i].pinned, plan[i].want);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == PAUSE_AT) begin
				// drain before going on
				item_valid <= 1'b0;
				do @(posedge clk); while (pending_out.size() != 0);
			end
			push_item(draw_item(), pace(i), 1'b0, '0);
		end
		item_valid <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) $display("** url_percent_decoder: PASSED **");
		else $display("** url_percent_decoder: FAILED **");
		$finish;
	end

endmodule
